// ===== hdl/mse_pkg.sv =====
`default_nettype none

package mse_pkg;

    // Input sample width (signed Q4.12)
    localparam int DATA_W = 16;
    // Magnitude of a sample difference: |p - t| <= 65535
    localparam int MAG_W = 16;
    // Squared magnitude width
    localparam int SQ_W = 2 * MAG_W;
    // Running sum width (saturating)
    localparam int SUM_W = 47;
    // Result width (Q.24, two's complement)
    localparam int VALUE_W = 37;
    // Gradient scale: 2 * diff << 12 == diff << 13
    localparam int GRAD_SHIFT = 13;
    // Significant bits of the gradient dividend
    localparam int GRAD_W = MAG_W + GRAD_SHIFT;
    // Vector length register
    localparam int LEN_W = 13;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
    // Divider step counter, holds up to SUM_W
    localparam int STEP_W = $clog2(SUM_W + 1);
    // Default element count limit
    localparam int MAX_LENGTH_DEF = 4096;

    // Request codes
    localparam logic MODE_LOSS = 1'b0;
    localparam logic MODE_GRAD = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/mse_sqr.sv =====
`default_nettype none

// Bit-serial squarer: one shift-add per cycle, one per multiplier bit.
module mse_sqr (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [mse_pkg::MAG_W-1:0]   mag,
    output logic                             done,
    output logic [mse_pkg::SQ_W-1:0]         product
);

    localparam int W = mse_pkg::MAG_W;
    localparam int CNT_W = $clog2(W);

    logic [2*W-1:0]   prod_reg;
    logic [2*W-1:0]   prod_next;
    logic [W-1:0]     mcand_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       upper;

    // Add the multiplicand on a set multiplier bit, then shift right
    always_comb begin
        upper     = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {upper, prod_reg[W-1:1]};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg  <= {{W{1'b0}}, mag};
            mcand_reg <= mag;
        end else if (busy_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

// ===== hdl/mse_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned; once 'steps' quotient bits are shifted in, the quotient sits in the low bits.
module mse_div #(
    parameter int DVS_W = mse_pkg::LEN_W
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [mse_pkg::SUM_W-1:0]    dividend,
    input  wire logic [DVS_W-1:0]             divisor,
    input  wire logic [mse_pkg::STEP_W-1:0]   steps,
    output logic                              done,
    output logic [mse_pkg::SUM_W-1:0]         quotient
);

    localparam int DVD_W = mse_pkg::SUM_W;

    logic [DVD_W-1:0]            dvd_reg;
    logic [DVS_W-1:0]            rem_reg;
    logic [DVS_W-1:0]            dvs_reg;
    logic [mse_pkg::STEP_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DVS_W:0]              trial;
    logic                        qbit;

    // One trial subtraction
    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]} - {1'b0, dvs_reg};
        qbit  = ~trial[DVS_W];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps - 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
            rem_reg <= qbit ? trial[DVS_W-1:0] : {rem_reg[DVS_W-2:0], dvd_reg[DVD_W-1]};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== hdl/mean_squared_error_loss_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     s_mode, s_prediction, s_target, s_last
// m_        out        m_valid / m_ready     m_value, m_is_loss
// cfg_      in         cfg_valid / cfg_ready cfg_vector_length
//
// One request at a time. Gradient: the divider runs 29 steps, then the result is
// loaded into the output register. Loss not last: the squarer runs 16 steps and the
// product is added to the running sum. Loss marked last: 16 squarer plus 47 divider
// steps, then the result is loaded into the output register.
// Synchronous active-low reset clears control, sum, count and vector_length (to 1).
// A result waiting on m_ready stalls nothing until the next result is ready;
// that one then holds the sequencer and s_ready stays low until m_ready.
module mean_squared_error_loss_unit #(
    parameter int MAX_LENGTH = mse_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic signed [mse_pkg::DATA_W-1:0] s_prediction,
    input  wire logic signed [mse_pkg::DATA_W-1:0] s_target,
    input  wire logic                              s_last,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [mse_pkg::VALUE_W-1:0]     m_value,
    output logic                                   m_is_loss,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mse_pkg::LEN_W-1:0]         cfg_vector_length
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int DVS_W = (CNT_W > mse_pkg::LEN_W) ? CNT_W : mse_pkg::LEN_W;
    localparam int SUM_W = mse_pkg::SUM_W;
    localparam int MAG_W = mse_pkg::MAG_W;
    localparam int VALUE_W = mse_pkg::VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQR,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [mse_pkg::LEN_W-1:0] len_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     neg_reg;
    logic                     loss_reg;
    logic                     last_reg;
    logic                     m_valid_reg;
    logic [VALUE_W-1:0]       m_value_reg;
    logic                     m_is_loss_reg;

    logic [mse_pkg::DATA_W:0] diff;
    logic [mse_pkg::DATA_W:0] diff_abs;
    logic                     sqr_start;
    logic                     sqr_done;
    logic [mse_pkg::SQ_W-1:0] sqr_product;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_W-1:0]         div_dividend;
    logic [DVS_W-1:0]         div_divisor;
    logic [mse_pkg::STEP_W-1:0] div_steps;
    logic [SUM_W-1:0]         quotient;
    logic [SUM_W:0]           sum_wide;
    logic [mse_pkg::LEN_W-1:0] len_eff;
    logic [VALUE_W-1:0]       quo_val;
    logic                     out_free;
    logic                     req_accept;

    assign req_accept = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;

    // Difference and its magnitude
    always_comb begin
        diff     = {s_prediction[mse_pkg::DATA_W-1], s_prediction}
                 - {s_target[mse_pkg::DATA_W-1], s_target};
        diff_abs = diff[mse_pkg::DATA_W] ? -diff : diff;
    end

    // Saturating accumulate and count
    always_comb begin
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sqr_product);
        sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        cnt_next = (cnt_reg < CNT_W'(MAX_LENGTH)) ? cnt_reg + 1'b1 : cnt_reg;
    end

    // Squarer starts on a loss request
    assign sqr_start = req_accept && (s_mode == mse_pkg::MODE_LOSS);

    // Divider request: gradient from the accept, loss on the last element
    always_comb begin
        len_eff = (len_reg == '0) ? mse_pkg::LEN_W'(1) : len_reg;
        if (state_reg == ST_IDLE) begin
            div_start    = req_accept && (s_mode == mse_pkg::MODE_GRAD);
            div_dividend = {diff_abs[MAG_W-1:0], {(SUM_W - MAG_W){1'b0}}};
            div_divisor  = DVS_W'(len_eff);
            div_steps    = mse_pkg::STEP_W'(mse_pkg::GRAD_W);
        end else begin
            div_start    = (state_reg == ST_SQR) && sqr_done && last_reg;
            div_dividend = sum_next;
            div_divisor  = DVS_W'(cnt_next);
            div_steps    = mse_pkg::STEP_W'(SUM_W);
        end
    end

    mse_sqr u_sqr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqr_start),
        .mag     (diff_abs[MAG_W-1:0]),
        .done    (sqr_done),
        .product (sqr_product)
    );

    mse_div #(
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (quotient)
    );

    // Signed result from the quotient magnitude
    assign quo_val = neg_reg ? -quotient[VALUE_W-1:0] : quotient[VALUE_W-1:0];

    // Sequencer, accumulators and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= mse_pkg::LEN_RESET;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            neg_reg     <= 1'b0;
            loss_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                len_reg <= cfg_vector_length;
            end
            // a new result in the output state replaces the one taken
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (req_accept) begin
                        loss_reg  <= (s_mode == mse_pkg::MODE_LOSS);
                        last_reg  <= s_last;
                        neg_reg   <= (s_mode == mse_pkg::MODE_GRAD) && diff[mse_pkg::DATA_W];
                        state_reg <= (s_mode == mse_pkg::MODE_GRAD) ? ST_DIV : ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (sqr_done) begin
                        if (last_reg) begin
                            sum_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV;
                        end else begin
                            sum_reg   <= sum_next;
                            cnt_reg   <= cnt_next;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_value_reg   <= quo_val;
                        m_is_loss_reg <= loss_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;
    assign m_is_loss = m_is_loss_reg;

    // Element count never passes its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LENGTH))
        else $error("element count above limit");

    // A new result is only loaded from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside output state");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // Gradient elements stay within the sign-extended gradient range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_loss) |->
            ($countones(m_value[VALUE_W-1:mse_pkg::GRAD_W]) == 0 ||
             $countones(m_value[VALUE_W-1:mse_pkg::GRAD_W]) == VALUE_W - mse_pkg::GRAD_W))
        else $error("gradient element out of range");

endmodule

`default_nettype wire
